@@ design/mra_pkg.sv @@
package mra_pkg;

  localparam int ACCUM_WIDTH = 16;
  localparam int MAX_SCALES  = 8;
  localparam int POS_W       = 16;
  localparam int DELTA_W     = 7;
  localparam int BYTE_W      = 8;
  localparam int TBL_IDX_W   = 3;
  localparam int CNT_W       = 4;
  localparam int SUM_W       = ACCUM_WIDTH + 1;
  localparam int PROD_W      = ACCUM_WIDTH + BYTE_W + 1;
  localparam int UNIT_W      = PROD_W + 1;
  localparam int KIND_W      = 3;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;
  localparam int IN_DATA_W   = 24;
  localparam int OUT_DATA_W  = 32;

  // input tdata layout
  localparam int IN_LEFT_BIT  = 0;
  localparam int IN_RIGHT_BIT = 1;
  localparam int IN_DX_LSB    = 2;
  localparam int IN_DY_LSB    = IN_DX_LSB + DELTA_W;
  localparam int IN_FORCE_BIT = IN_DY_LSB + DELTA_W;
  localparam int IN_SKIP_BIT  = IN_FORCE_BIT + 1;

  localparam logic [CFG_DATA_W-1:0] RST_THRESHOLDS = 64'h0000_0006_0504_0302;
  localparam logic [CFG_DATA_W-1:0] RST_FACTORS    = 64'h0000_000A_0806_0402;
  localparam logic [CNT_W-1:0]      RST_COUNT      = 4'd5;
  localparam logic signed [POS_W-1:0] RST_CURSOR   = 16'sd100;

  typedef enum logic [KIND_W-1:0] {
    EV_LEFT_DOWN  = 3'd0,
    EV_LEFT_UP    = 3'd1,
    EV_RIGHT_DOWN = 3'd2,
    EV_RIGHT_UP   = 3'd3,
    EV_MOVE       = 3'd4
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BUTTONS_TIED     = 3'd0,
    REG_LEFT_HANDED      = 3'd1,
    REG_SCALE_COUNT      = 3'd2,
    REG_SCALE_THRESHOLDS = 3'd3,
    REG_SCALE_FACTORS    = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    UOP_NONE,
    UOP_ACC,
    UOP_ABS,
    UOP_MUL,
    UOP_CUR,
    UOP_CMP
  } unit_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ACC_X,
    ST_ACC_Y,
    ST_CHECK,
    ST_ABS,
    ST_THR0,
    ST_SEARCH,
    ST_MUL_X,
    ST_MUL_Y,
    ST_CUR_X,
    ST_CUR_Y,
    ST_ISSUE,
    ST_WAIT
  } state_t;

  typedef logic signed [UNIT_W-1:0] unit_word_t;

  localparam unit_word_t ACC_MAX =
    {{(UNIT_W-ACCUM_WIDTH+1){1'b0}}, {(ACCUM_WIDTH-1){1'b1}}};
  localparam unit_word_t ACC_MIN = ~ACC_MAX;
  localparam unit_word_t POS_MAX =
    {{(UNIT_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
  localparam unit_word_t POS_MIN = ~POS_MAX;

  typedef struct packed {
    logic                  buttons_tied;
    logic                  left_handed;
    logic [CNT_W-1:0]      count;
    logic [BYTE_W-1:0]     thr;
    logic [BYTE_W-1:0]     fac;
  } cfg_view_t;

  typedef struct packed {
    logic [TBL_IDX_W-1:0] thr_idx;
    logic [TBL_IDX_W-1:0] fac_idx;
  } tbl_sel_t;

  typedef struct packed {
    unit_op_t   op;
    unit_word_t a;
    unit_word_t b;
  } unit_req_t;

  typedef struct packed {
    unit_word_t y;
    logic       le;
  } unit_rsp_t;

  function automatic unit_word_t ext_acc(input logic signed [ACCUM_WIDTH-1:0] v);
    return {{(UNIT_W-ACCUM_WIDTH){v[ACCUM_WIDTH-1]}}, v};
  endfunction

  function automatic unit_word_t ext_pos(input logic signed [POS_W-1:0] v);
    return {{(UNIT_W-POS_W){v[POS_W-1]}}, v};
  endfunction

  function automatic unit_word_t ext_prod(input logic signed [PROD_W-1:0] v);
    return {{(UNIT_W-PROD_W){v[PROD_W-1]}}, v};
  endfunction

  function automatic unit_word_t ext_delta(input logic [DELTA_W-1:0] v);
    return {{(UNIT_W-DELTA_W){v[DELTA_W-1]}}, v};
  endfunction

  function automatic unit_word_t ext_byte(input logic [BYTE_W-1:0] v);
    return {{(UNIT_W-BYTE_W){1'b0}}, v};
  endfunction

  function automatic unit_word_t ext_sum(input logic [SUM_W-1:0] v);
    return {{(UNIT_W-SUM_W){1'b0}}, v};
  endfunction

endpackage

@@ design/mra_unit.sv @@
module mra_unit (
  input  mra_pkg::unit_req_t req,
  output mra_pkg::unit_rsp_t rsp
);
  import mra_pkg::*;

  unit_word_t                diff;
  unit_word_t                total;
  unit_word_t                abs_a;
  unit_word_t                abs_b;
  logic signed [ACCUM_WIDTH-1:0] mul_a;
  logic signed [BYTE_W:0]    mul_b;
  logic signed [PROD_W-1:0]  prod;

  always_comb begin
    diff  = req.a - req.b;
    total = req.a + req.b;
    abs_a = req.a[UNIT_W-1] ? -req.a : req.a;
    abs_b = req.b[UNIT_W-1] ? -req.b : req.b;
    mul_a = req.a[ACCUM_WIDTH-1:0];
    mul_b = {1'b0, req.b[BYTE_W-1:0]};
    prod  = mul_a * mul_b;

    rsp.y  = '0;
    rsp.le = 1'b0;
    unique case (req.op)
      UOP_NONE: rsp.y = '0;
      UOP_ACC: begin
        if (diff > ACC_MAX) begin
          rsp.y = ACC_MAX;
        end else if (diff < ACC_MIN) begin
          rsp.y = ACC_MIN;
        end else begin
          rsp.y = diff;
        end
      end
      UOP_ABS: rsp.y = abs_a + abs_b;
      UOP_MUL: rsp.y = ext_prod(prod);
      UOP_CUR: begin
        if (total > POS_MAX) begin
          rsp.y = POS_MAX;
        end else if (total < POS_MIN) begin
          rsp.y = POS_MIN;
        end else begin
          rsp.y = total;
        end
      end
      UOP_CMP: rsp.le = (req.a <= req.b);
    endcase
  end

endmodule

@@ design/mra_cfg.sv @@
module mra_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mra_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mra_pkg::CFG_DATA_W-1:0] cfg_data,
  input  mra_pkg::tbl_sel_t             tbl_sel,
  output mra_pkg::cfg_view_t            cfg_view
);
  import mra_pkg::*;

  logic                  buttons_tied_r;
  logic                  left_handed_r;
  logic [CNT_W-1:0]      scale_count_r;
  logic [CFG_DATA_W-1:0] thresholds_r;
  logic [CFG_DATA_W-1:0] factors_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buttons_tied_r <= 1'b1;
      left_handed_r  <= 1'b0;
      scale_count_r  <= RST_COUNT;
      thresholds_r   <= RST_THRESHOLDS;
      factors_r      <= RST_FACTORS;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_BUTTONS_TIED:     buttons_tied_r <= cfg_data[0];
        REG_LEFT_HANDED:      left_handed_r  <= cfg_data[0];
        REG_SCALE_COUNT:      scale_count_r  <= cfg_data[CNT_W-1:0];
        REG_SCALE_THRESHOLDS: thresholds_r   <= cfg_data;
        REG_SCALE_FACTORS:    factors_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp the entry count into 1..MAX_SCALES
  always_comb begin
    cfg_view.buttons_tied = buttons_tied_r;
    cfg_view.left_handed  = left_handed_r;
    if (scale_count_r == '0) begin
      cfg_view.count = CNT_W'(1);
    end else if (scale_count_r > CNT_W'(MAX_SCALES)) begin
      cfg_view.count = CNT_W'(MAX_SCALES);
    end else begin
      cfg_view.count = scale_count_r;
    end
    cfg_view.thr = thresholds_r[tbl_sel.thr_idx*BYTE_W +: BYTE_W];
    cfg_view.fac = factors_r[tbl_sel.fac_idx*BYTE_W +: BYTE_W];
  end

endmodule

@@ design/mra_ctrl.sv @@
module mra_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [mra_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [mra_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic [mra_pkg::KIND_W-1:0]     out_tuser,
  output logic                          out_tlast,
  input  mra_pkg::cfg_view_t            cfg_view,
  output mra_pkg::tbl_sel_t             tbl_sel,
  output mra_pkg::unit_req_t            unit_req,
  input  mra_pkg::unit_rsp_t            unit_rsp
);
  import mra_pkg::*;

  state_t state_r, state_nxt;

  logic                          left_down_r, right_down_r;
  logic signed [ACCUM_WIDTH-1:0] accum_x_r, accum_y_r;
  logic signed [POS_W-1:0]       cursor_x_r, cursor_y_r;
  logic                          pend_l_r, pend_r_r, pend_m_r;
  logic                          out_valid_r;

  event_kind_t                   kind_l_r, kind_r_r;
  logic [DELTA_W-1:0]            delta_x_r, delta_y_r;
  logic                          force_r, skip_r;
  logic signed [PROD_W-1:0]      dx_r, dy_r;
  logic [SUM_W-1:0]              sum_r;
  logic [CNT_W-1:0]              idx_r;
  logic [BYTE_W-1:0]             fac_r;
  event_kind_t                   out_kind_r;
  logic                          out_last_r;
  logic signed [POS_W-1:0]       out_x_r, out_y_r;

  logic accept, is_tick;
  logic l_raw, r_raw, l_cond, r_cond, lp, rp;
  logic tick_moves, search_done;
  logic [CNT_W-1:0] fac_pick;

  // button conditioning, move and search decisions
  always_comb begin
    accept  = in_tvalid && in_tready;
    is_tick = in_tuser;
    l_raw   = in_tdata[IN_LEFT_BIT];
    r_raw   = in_tdata[IN_RIGHT_BIT];
    if (cfg_view.buttons_tied) begin
      l_cond = l_raw & r_raw;
      r_cond = 1'b1;
    end else if (cfg_view.left_handed) begin
      l_cond = r_raw;
      r_cond = l_raw;
    end else begin
      l_cond = l_raw;
      r_cond = r_raw;
    end
    lp = !l_cond;
    rp = !r_cond;
    tick_moves  = force_r || (accum_x_r != '0) || (accum_y_r != '0);
    search_done = (idx_r >= cfg_view.count) || unit_rsp.le;
    fac_pick    = idx_r - CNT_W'(1);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          state_nxt = is_tick ? ST_CHECK : ST_ACC_X;
        end
      end
      ST_ACC_X:  state_nxt = ST_ACC_Y;
      ST_ACC_Y:  state_nxt = ST_ISSUE;
      ST_CHECK: begin
        priority if (!tick_moves) begin
          state_nxt = ST_IDLE;
        end else if (skip_r) begin
          state_nxt = ST_CUR_X;
        end else begin
          state_nxt = ST_ABS;
        end
      end
      ST_ABS:    state_nxt = ST_THR0;
      ST_THR0:   state_nxt = unit_rsp.le ? ST_CUR_X : ST_SEARCH;
      ST_SEARCH: state_nxt = search_done ? ST_MUL_X : ST_SEARCH;
      ST_MUL_X:  state_nxt = ST_MUL_Y;
      ST_MUL_Y:  state_nxt = ST_CUR_X;
      ST_CUR_X:  state_nxt = ST_CUR_Y;
      ST_CUR_Y:  state_nxt = ST_ISSUE;
      ST_ISSUE: begin
        if (pend_l_r || pend_r_r || pend_m_r) begin
          state_nxt = ST_WAIT;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WAIT: begin
        if (out_tready) begin
          state_nxt = ST_ISSUE;
        end
      end
      default:   state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready        = (state_r == ST_IDLE);
    unit_req.op      = UOP_NONE;
    unit_req.a       = '0;
    unit_req.b       = '0;
    tbl_sel.thr_idx  = idx_r[TBL_IDX_W-1:0];
    tbl_sel.fac_idx  = fac_pick[TBL_IDX_W-1:0];
    unique case (state_r)
      ST_ACC_X: begin
        unit_req.op = UOP_ACC;
        unit_req.a  = ext_acc(accum_x_r);
        unit_req.b  = ext_delta(delta_x_r);
      end
      ST_ACC_Y: begin
        unit_req.op = UOP_ACC;
        unit_req.a  = ext_acc(accum_y_r);
        unit_req.b  = ext_delta(delta_y_r);
      end
      ST_ABS: begin
        unit_req.op = UOP_ABS;
        unit_req.a  = ext_acc(accum_x_r);
        unit_req.b  = ext_acc(accum_y_r);
      end
      ST_THR0: begin
        unit_req.op     = UOP_CMP;
        unit_req.a      = ext_sum(sum_r);
        unit_req.b      = ext_byte(cfg_view.thr);
        tbl_sel.thr_idx = '0;
      end
      ST_SEARCH: begin
        unit_req.op = UOP_CMP;
        unit_req.a  = ext_sum(sum_r);
        unit_req.b  = ext_byte(cfg_view.thr);
      end
      ST_MUL_X: begin
        unit_req.op = UOP_MUL;
        unit_req.a  = ext_acc(accum_x_r);
        unit_req.b  = ext_byte(fac_r);
      end
      ST_MUL_Y: begin
        unit_req.op = UOP_MUL;
        unit_req.a  = ext_acc(accum_y_r);
        unit_req.b  = ext_byte(fac_r);
      end
      ST_CUR_X: begin
        unit_req.op = UOP_CUR;
        unit_req.a  = ext_pos(cursor_x_r);
        unit_req.b  = ext_prod(dx_r);
      end
      ST_CUR_Y: begin
        unit_req.op = UOP_CUR;
        unit_req.a  = ext_pos(cursor_y_r);
        unit_req.b  = ext_prod(dy_r);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      left_down_r  <= 1'b0;
      right_down_r <= 1'b0;
      accum_x_r    <= '0;
      accum_y_r    <= '0;
      cursor_x_r   <= RST_CURSOR;
      cursor_y_r   <= RST_CURSOR;
      pend_l_r     <= 1'b0;
      pend_r_r     <= 1'b0;
      pend_m_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (accept && !is_tick) begin
            pend_l_r     <= (lp != left_down_r);
            pend_r_r     <= (rp != right_down_r);
            left_down_r  <= lp;
            right_down_r <= rp;
          end
        end
        ST_ACC_X: accum_x_r <= unit_rsp.y[ACCUM_WIDTH-1:0];
        ST_ACC_Y: accum_y_r <= unit_rsp.y[ACCUM_WIDTH-1:0];
        ST_CUR_X: cursor_x_r <= unit_rsp.y[POS_W-1:0];
        ST_CUR_Y: begin
          cursor_y_r <= unit_rsp.y[POS_W-1:0];
          accum_x_r  <= '0;
          accum_y_r  <= '0;
          pend_m_r   <= 1'b1;
        end
        ST_ISSUE: begin
          priority if (pend_l_r) begin
            pend_l_r    <= 1'b0;
            out_valid_r <= 1'b1;
          end else if (pend_r_r) begin
            pend_r_r    <= 1'b0;
            out_valid_r <= 1'b1;
          end else if (pend_m_r) begin
            pend_m_r    <= 1'b0;
            out_valid_r <= 1'b1;
          end
        end
        ST_WAIT: begin
          if (out_tready) begin
            out_valid_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          delta_x_r <= in_tdata[IN_DX_LSB +: DELTA_W];
          delta_y_r <= in_tdata[IN_DY_LSB +: DELTA_W];
          force_r   <= in_tdata[IN_FORCE_BIT];
          skip_r    <= in_tdata[IN_SKIP_BIT];
          kind_l_r  <= lp ? EV_LEFT_DOWN : EV_LEFT_UP;
          kind_r_r  <= rp ? EV_RIGHT_DOWN : EV_RIGHT_UP;
        end
      end
      ST_CHECK: begin
        // unscaled motion, overwritten when a factor applies
        dx_r <= {{(PROD_W-ACCUM_WIDTH){accum_x_r[ACCUM_WIDTH-1]}}, accum_x_r};
        dy_r <= {{(PROD_W-ACCUM_WIDTH){accum_y_r[ACCUM_WIDTH-1]}}, accum_y_r};
      end
      ST_ABS:  sum_r <= unit_rsp.y[SUM_W-1:0];
      ST_THR0: idx_r <= CNT_W'(1);
      ST_SEARCH: begin
        if (search_done) begin
          fac_r <= cfg_view.fac;
        end else begin
          idx_r <= idx_r + CNT_W'(1);
        end
      end
      ST_MUL_X: dx_r <= unit_rsp.y[PROD_W-1:0];
      ST_MUL_Y: dy_r <= unit_rsp.y[PROD_W-1:0];
      ST_ISSUE: begin
        out_x_r <= cursor_x_r;
        out_y_r <= cursor_y_r;
        priority if (pend_l_r) begin
          out_kind_r <= kind_l_r;
          out_last_r <= !pend_r_r;
        end else if (pend_r_r) begin
          out_kind_r <= kind_r_r;
          out_last_r <= 1'b1;
        end else begin
          out_kind_r <= EV_MOVE;
          out_last_r <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_y_r, out_x_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

@@ design/mouse_report_accelerator.sv @@
// Mouse report accelerator. The input stream carries mouse reports (tuser 0)
// and vertical retrace ticks (tuser 1). A report conditions the active-low
// buttons, emits a down or up event for each button that changed (left
// first) and adds the negated 7-bit deltas into saturating accumulators. A
// tick that is forced or finds motion emits one cursor move, scaled by the
// factor picked from the threshold table unless skip_scaling is set or the
// summed absolute motion is within the first threshold. Every result
// carries the cursor position; tlast marks the final result of an input.
// One item is handled at a time and in_tready is high only when the block
// is idle. All arithmetic goes through one shared unit under a small
// sequencer: a report updates the x then y accumulator, then issues its
// events; a moving tick without skip_scaling sums the absolute motion and
// runs the one-entry-per-cycle threshold search, multiplies x then y if a
// factor applies, then updates the cursor x then y. Configuration writes
// are always accepted and take effect at once.
module mouse_report_accelerator
  import mra_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [0] left_raw, [1] right_raw, [8:2] delta_x, [15:9] delta_y,
  // [16] force_move, [17] skip_scaling, [23:18] zero
  input  logic [IN_DATA_W-1:0]   in_tdata,
  // [0] action
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [15:0] pos_x, [31:16] pos_y
  output logic [OUT_DATA_W-1:0]  out_tdata,
  // [2:0] event_kind
  output logic [KIND_W-1:0]      out_tuser,
  output logic                   out_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_view_t cfg_view;
  tbl_sel_t  tbl_sel;
  unit_req_t unit_req;
  unit_rsp_t unit_rsp;

  mra_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tbl_sel   (tbl_sel),
    .cfg_view  (cfg_view)
  );

  mra_unit u_unit (
    .req (unit_req),
    .rsp (unit_rsp)
  );

  mra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_view   (cfg_view),
    .tbl_sel    (tbl_sel),
    .unit_req   (unit_req),
    .unit_rsp   (unit_rsp)
  );

endmodule

@@ design/mra_checker.sv @@
module mra_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import mra_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

  // one item at a time: no new transfer in the cycle after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while busy");

  // no input is taken while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // only a left button event can be followed by another result
  a_first_is_left: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |->
      (out_tuser == EV_LEFT_DOWN) || (out_tuser == EV_LEFT_UP))
    else $error("non-final result is not a left event");

  // a move result ends its input
  a_move_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == EV_MOVE) |-> out_tlast)
    else $error("move result without tlast");

endmodule

bind mouse_report_accelerator mra_checker u_mra_checker (.*);
